[rtl/traveling_wave_line_decoupler_macros.svh]
// ----------------------------------------------------------------------------
// traveling wave line decoupler assertion macros
// shared property forms for the decoupler checks
// ----------------------------------------------------------------------------
`ifndef TRAVELING_WAVE_LINE_DECOUPLER_MACROS_SVH
`define TRAVELING_WAVE_LINE_DECOUPLER_MACROS_SVH

// condition implies consequence in the same cycle
`define TWLD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the next cycle
`define TWLD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/twld_pkg.sv]
// ----------------------------------------------------------------------------
// twld_pkg
// widths, codes and saturating helpers for the traveling wave line decoupler
// ----------------------------------------------------------------------------
package twld_pkg;

   localparam int RING_DEPTH = 1024;
   localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int LEN_W      = $clog2(RING_DEPTH + 1);
   localparam int DATA_W     = 48;
   localparam int GAIN_W     = 32;
   localparam int WEIGHT_W   = 17;
   localparam int SLOTS_W    = 11;
   localparam int OP_W       = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int WIDE_W     = 68;
   localparam int LO_W       = 24;
   localparam int PH_W       = DATA_W - LO_W + GAIN_W;
   localparam int PL_W       = LO_W + 1 + GAIN_W;
   localparam int ENTRY_W    = 4 * DATA_W;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [GAIN_W-1:0] gain_type;
   typedef logic signed [WIDE_W-1:0] wide_type;
   typedef logic [OP_W-1:0]          op_type;
   typedef logic [CSR_IDX_W-1:0]     csr_idx_type;

   localparam op_type OP_LOAD   = 2'd0;
   localparam op_type OP_START  = 2'd1;
   localparam op_type OP_UPDATE = 2'd2;

   localparam csr_idx_type CSR_GAIN_SURGE       = 3'd0;
   localparam csr_idx_type CSR_GAIN_LOSS        = 3'd1;
   localparam csr_idx_type CSR_SURGE_MINUS_LOSS = 3'd2;
   localparam csr_idx_type CSR_INIT_GAIN        = 3'd3;
   localparam csr_idx_type CSR_INTERP_WEIGHT    = 3'd4;
   localparam csr_idx_type CSR_DELAY_SLOTS      = 3'd5;

   localparam logic [WEIGHT_W-1:0] ONE_Q16 = WEIGHT_W'(65536);

   function automatic wide_type widen(input data_type d);
      return WIDE_W'(d);
   endfunction

   function automatic data_type sat_data(input wide_type x);
      wide_type hi_lim;
      wide_type lo_lim;
      hi_lim = $signed({{(WIDE_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}});
      lo_lim = $signed({{(WIDE_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}});
      if (x > hi_lim) begin
         return hi_lim[DATA_W-1:0];
      end else if (x < lo_lim) begin
         return lo_lim[DATA_W-1:0];
      end
      return x[DATA_W-1:0];
   endfunction

endpackage

[rtl/twld_ram.sv]
// ----------------------------------------------------------------------------
// twld_ram
// single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module twld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/traveling_wave_line_decoupler.sv]
// ----------------------------------------------------------------------------
// traveling wave line decoupler
// lossy line model: delay rings per line end and history source currents
// ----------------------------------------------------------------------------
// A load word is taken and the next word may follow at once. A start word
// runs the read, interpolation, multiply and add states before the next
// word can be taken; an update word adds three gain states and a final one.
// This is set by the ring memory, whose single read port reads the two
// interpolation entries in turn, and by the two shared multiplier lanes,
// each two stages deep, which an update uses three times. A finished result
// waits in the output register while the next word is accepted. The rings
// come up undefined and must be filled by load words before they are read.
module traveling_wave_line_decoupler (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  twld_pkg::csr_idx_type        csr_index,
   input  logic [twld_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  twld_pkg::op_type             req_operation,
   input  twld_pkg::data_type           req_end1_voltage,
   input  twld_pkg::data_type           req_end1_current,
   input  twld_pkg::data_type           req_end2_voltage,
   input  twld_pkg::data_type           req_end2_current,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output twld_pkg::data_type           rsp_source1_current,
   output twld_pkg::data_type           rsp_source2_current
);
   import twld_pkg::*;
   `include "traveling_wave_line_decoupler_macros.svh"

   typedef enum logic [3:0] {
      S_IDLE, S_RD_I, S_RD_J, S_INTERP, S_M1, S_M2, S_ADD, S_GA, S_GB, S_GC, S_FIN
   } state_type;

   state_type state_ff;
   logic      is_start_ff;
   logic [IDX_W-1:0] idx_ff;
   data_type  last1_ff, last2_ff;
   gain_type  gain_surge_ff, gain_loss_ff, sml_ff, init_gain_ff;
   logic [WEIGHT_W-1:0] weight_ff;
   logic [SLOTS_W-1:0]  slots_ff;

   logic      rsp_valid_ff;
   data_type  rsp_s1_ff, rsp_s2_ff;

   // ring entry i held while entry j is read
   data_type  hv1_ff, hc1_ff, hv2_ff, hc2_ff;
   data_type  v1_ff, c1_ff, v2_ff, c2_ff;
   data_type  a1_ff, a2_ff;
   data_type  qa_ff [2];
   logic signed [PH_W-1:0] ph_ff [2];
   logic signed [PL_W-1:0] pl_ff [2];
   data_type  p_ff [2];

   logic accept, out_ok, ram_we, rsp_fire;
   logic [LEN_W-1:0] ring_len, idx_plus;
   logic [IDX_W-1:0] idx_adv, rd_addr;
   logic [ENTRY_W-1:0] wr_data, rd_data;
   logic [WEIGHT_W-1:0] alpha;
   data_type  rv1, rc1, rv2, rc2;
   data_type  op_x [2];
   gain_type  op_g [2];
   logic      st1_en, st2_en;
   data_type  start_s1, start_s2, fin_s1, fin_s2;

   function automatic data_type interp(input data_type a, input data_type b,
                                       input logic [WEIGHT_W-1:0] al);
      logic signed [DATA_W:0] diff;
      logic signed [DATA_W+WEIGHT_W+1:0] prod;
      wide_type sum;
      diff = (DATA_W+1)'(a) - (DATA_W+1)'(b);
      prod = diff * $signed({1'b0, al});
      sum  = widen(b) + WIDE_W'(prod >>> 16);
      return sum[DATA_W-1:0];
   endfunction

   function automatic data_type mul_combine(input logic signed [PH_W-1:0] ph,
                                            input logic signed [PL_W-1:0] pl);
      wide_type r;
      r = (WIDE_W'(ph) <<< 8) + WIDE_W'(pl >>> 16);
      return sat_data(r);
   endfunction

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_ok    = !rsp_valid_ff || rsp_ready;
   assign rsp_fire  = out_ok && ((state_ff == S_ADD && is_start_ff) || state_ff == S_FIN);

   always_comb begin
      if (slots_ff == '0) begin
         ring_len = LEN_W'(1);
      end else if (32'(slots_ff) > 32'(RING_DEPTH)) begin
         ring_len = LEN_W'(RING_DEPTH);
      end else begin
         ring_len = LEN_W'(slots_ff);
      end
   end

   assign idx_plus = LEN_W'(idx_ff) + LEN_W'(1);
   assign idx_adv  = (idx_plus >= ring_len) ? '0 : idx_plus[IDX_W-1:0];
   assign alpha    = (weight_ff > ONE_Q16) ? ONE_Q16 : weight_ff;

   // update stores negated voltages and corrected currents
   assign ram_we = accept && (req_operation == OP_LOAD || req_operation == OP_UPDATE);
   always_comb begin
      if (req_operation == OP_UPDATE) begin
         wr_data = {sat_data(-widen(req_end1_voltage)),
                    sat_data(widen(last1_ff) - widen(req_end1_current)),
                    sat_data(-widen(req_end2_voltage)),
                    sat_data(widen(last2_ff) - widen(req_end2_current))};
      end else begin
         wr_data = {req_end1_voltage, req_end1_current, req_end2_voltage, req_end2_current};
      end
   end

   assign rd_addr = (state_ff == S_RD_I) ? idx_ff : idx_adv;

   twld_ram #(.WIDTH(ENTRY_W), .DEPTH(RING_DEPTH)) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rv1 = rd_data[4*DATA_W-1:3*DATA_W];
   assign rc1 = rd_data[3*DATA_W-1:2*DATA_W];
   assign rv2 = rd_data[2*DATA_W-1:DATA_W];
   assign rc2 = rd_data[DATA_W-1:0];

   // multiplier lane operands
   always_comb begin
      case (state_ff)
         S_M1: begin
            op_x[0] = is_start_ff ? v1_ff : c1_ff;
            op_x[1] = is_start_ff ? v2_ff : c2_ff;
            op_g[0] = is_start_ff ? init_gain_ff : sml_ff;
            op_g[1] = op_g[0];
         end
         S_GA: begin
            op_x[0] = a2_ff;
            op_x[1] = a1_ff;
            op_g[0] = gain_surge_ff;
            op_g[1] = gain_surge_ff;
         end
         default: begin
            op_x[0] = a1_ff;
            op_x[1] = a2_ff;
            op_g[0] = gain_loss_ff;
            op_g[1] = gain_loss_ff;
         end
      endcase
   end

   assign st1_en = (state_ff == S_M1) || (state_ff == S_GA) || (state_ff == S_GB);
   assign st2_en = (state_ff == S_M2) || (state_ff == S_GB) || (state_ff == S_GC);

   assign start_s1 = sat_data(widen(c1_ff) - widen(p_ff[0]));
   assign start_s2 = sat_data(widen(c2_ff) - widen(p_ff[1]));
   assign fin_s1   = sat_data(-widen(sat_data(widen(qa_ff[0]) + widen(p_ff[0]))));
   assign fin_s2   = sat_data(-widen(sat_data(widen(qa_ff[1]) + widen(p_ff[1]))));

   always_ff @(posedge clock) begin
      for (int k = 0; k < 2; k++) begin
         if (st1_en) begin
            ph_ff[k] <= $signed(op_x[k][DATA_W-1:LO_W]) * op_g[k];
            pl_ff[k] <= $signed({1'b0, op_x[k][LO_W-1:0]}) * op_g[k];
         end
         if (st2_en) begin
            p_ff[k] <= mul_combine(ph_ff[k], pl_ff[k]);
         end
         if (state_ff == S_GC) begin
            qa_ff[k] <= p_ff[k];
         end
      end
      if (state_ff == S_RD_J) begin
         hv1_ff <= rv1;
         hc1_ff <= rc1;
         hv2_ff <= rv2;
         hc2_ff <= rc2;
      end
      if (state_ff == S_INTERP) begin
         v1_ff <= interp(hv1_ff, rv1, alpha);
         c1_ff <= interp(hc1_ff, rc1, alpha);
         v2_ff <= interp(hv2_ff, rv2, alpha);
         c2_ff <= interp(hc2_ff, rc2, alpha);
      end
      if (state_ff == S_ADD) begin
         a1_ff <= sat_data(widen(v1_ff) + widen(p_ff[0]));
         a2_ff <= sat_data(widen(v2_ff) + widen(p_ff[1]));
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_surge_ff <= '0;
         gain_loss_ff  <= '0;
         sml_ff        <= '0;
         init_gain_ff  <= '0;
         weight_ff     <= ONE_Q16;
         slots_ff      <= SLOTS_W'(1024);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GAIN_SURGE:       gain_surge_ff <= csr_data;
            CSR_GAIN_LOSS:        gain_loss_ff  <= csr_data;
            CSR_SURGE_MINUS_LOSS: sml_ff        <= csr_data;
            CSR_INIT_GAIN:        init_gain_ff  <= csr_data;
            CSR_INTERP_WEIGHT:    weight_ff     <= csr_data[WEIGHT_W-1:0];
            CSR_DELAY_SLOTS:      slots_ff      <= csr_data[SLOTS_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer, ring index, output word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         is_start_ff  <= 1'b0;
         idx_ff       <= '0;
         last1_ff     <= '0;
         last2_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  case (req_operation)
                     OP_LOAD: begin
                        idx_ff <= idx_adv;
                     end
                     OP_START: begin
                        is_start_ff <= 1'b1;
                        state_ff    <= S_RD_I;
                     end
                     OP_UPDATE: begin
                        is_start_ff <= 1'b0;
                        idx_ff      <= idx_adv;
                        state_ff    <= S_RD_I;
                     end
                     default: ;
                  endcase
               end
            end
            S_RD_I:   state_ff <= S_RD_J;
            S_RD_J:   state_ff <= S_INTERP;
            S_INTERP: state_ff <= S_M1;
            S_M1:     state_ff <= S_M2;
            S_M2:     state_ff <= S_ADD;
            S_ADD: begin
               if (!is_start_ff) begin
                  state_ff <= S_GA;
               end else if (out_ok) begin
                  rsp_s1_ff    <= start_s1;
                  rsp_s2_ff    <= start_s2;
                  last1_ff     <= start_s1;
                  last2_ff     <= start_s2;
                  state_ff     <= S_IDLE;
               end
            end
            S_GA: state_ff <= S_GB;
            S_GB: state_ff <= S_GC;
            S_GC: state_ff <= S_FIN;
            S_FIN: begin
               if (out_ok) begin
                  rsp_s1_ff    <= fin_s1;
                  rsp_s2_ff    <= fin_s2;
                  last1_ff     <= fin_s1;
                  last2_ff     <= fin_s2;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_source1_current = rsp_s1_ff;
   assign rsp_source2_current = rsp_s2_ff;

   `TWLD_ASSERT_NOW(a_ring_write_idle, ram_we, state_ff == S_IDLE, "ring written while busy")
   `TWLD_ASSERT_NEXT(a_start_reads, accept && req_operation == OP_START, state_ff == S_RD_I && idx_ff == $past(idx_ff), "start moved ring index")
   `TWLD_ASSERT_NEXT(a_load_advance, accept && req_operation == OP_LOAD, state_ff == S_IDLE && (idx_ff == '0 || idx_ff == $past(idx_ff) + 1'b1), "bad index advance on load")
   `TWLD_ASSERT_NEXT(a_no_overwrite, rsp_valid_ff && !rsp_ready, rsp_valid_ff && $stable(rsp_s1_ff) && $stable(last1_ff), "pending word overwritten")

endmodule

[bench/traveling_wave_line_decoupler_tb.sv]
// ----------------------------------------------------------------------------
// traveling wave line decoupler testbench
// drives load, start and update words through the block under a range of
// gain, weight and ring length settings, predicts each pair of history source
// currents from a local line model and compares them with the block's output
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module traveling_wave_line_decoupler_tb;
   import twld_pkg::*;

   localparam op_type OP_UNUSED  = 2'd3;
   localparam int     QUIET_MAX  = 4000;
   localparam int     DRAIN_WAIT = 30;
   localparam int     PRELOAD_SLOTS = 128;
   localparam data_type DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam data_type DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef logic signed [127:0] big_type;
   typedef struct packed {
      data_type source1;
      data_type source2;
   } source_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_idx_type csr_index = CSR_GAIN_SURGE;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   op_type req_operation = OP_LOAD;
   data_type req_end1_voltage = '0;
   data_type req_end1_current = '0;
   data_type req_end2_voltage = '0;
   data_type req_end2_current = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   data_type rsp_source1_current;
   data_type rsp_source2_current;

   traveling_wave_line_decoupler u_top (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_operation(req_operation),
      .req_end1_voltage(req_end1_voltage), .req_end1_current(req_end1_current),
      .req_end2_voltage(req_end2_voltage), .req_end2_current(req_end2_current),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_source1_current(rsp_source1_current),
      .rsp_source2_current(rsp_source2_current)
   );

   // line model state
   data_type v1_ring [RING_DEPTH];
   data_type v2_ring [RING_DEPTH];
   data_type c1_ring [RING_DEPTH];
   data_type c2_ring [RING_DEPTH];
   int unsigned ring_pos;
   data_type last_src1, last_src2;
   gain_type surge_gain, loss_gain, surge_less_loss, start_gain;
   logic [WEIGHT_W-1:0] alpha;
   logic [SLOTS_W-1:0] slots;

   source_pair_type pending_sources[$];
   int errors = 0;
   int words_sent = 0;
   int results_seen = 0;
   int quiet = 0;
   bit idle_on = 1'b0;
   int stall_left = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic data_type sat48(input big_type x);
      if (x > big_type'(DATA_MAX)) return DATA_MAX;
      if (x < big_type'(DATA_MIN)) return DATA_MIN;
      return x[DATA_W-1:0];
   endfunction

   // exact product, floor shift by 16, then saturate
   function automatic data_type gain_mul(input data_type a, input gain_type g);
      big_type wa, wg;
      wa = big_type'(a);
      wg = big_type'(g);
      return sat48((wa * wg) >>> 16);
   endfunction

   function automatic int unsigned ring_length();
      if (slots < 1) return 1;
      if (slots > RING_DEPTH) return RING_DEPTH;
      return 32'(slots);
   endfunction

   function automatic data_type blend(input data_type newer, input data_type older);
      big_type w, acc;
      w = (alpha > ONE_Q16) ? big_type'(65536) : big_type'(alpha);
      acc = (w * big_type'(newer) + (big_type'(65536) - w) * big_type'(older)) >>> 16;
      return acc[DATA_W-1:0];
   endfunction

   task automatic advance_ring();
      ring_pos = (ring_pos + 1 >= ring_length()) ? 0 : ring_pos + 1;
   endtask

   task automatic predict_word(input op_type op, input data_type v1, input data_type c1,
                               input data_type v2, input data_type c2);
      int unsigned nxt;
      data_type iv1, iv2, ic1, ic2, a1, a2;
      source_pair_type pair;
      if (op == OP_UNUSED) return;
      if (op == OP_LOAD) begin
         v1_ring[ring_pos] = v1;
         c1_ring[ring_pos] = c1;
         v2_ring[ring_pos] = v2;
         c2_ring[ring_pos] = c2;
         advance_ring();
         return;
      end
      if (op == OP_UPDATE) begin
         v1_ring[ring_pos] = sat48(-big_type'(v1));
         v2_ring[ring_pos] = sat48(-big_type'(v2));
         c1_ring[ring_pos] = sat48(big_type'(last_src1) - big_type'(c1));
         c2_ring[ring_pos] = sat48(big_type'(last_src2) - big_type'(c2));
         advance_ring();
      end
      nxt = (ring_pos + 1 >= ring_length()) ? 0 : ring_pos + 1;
      iv1 = blend(v1_ring[ring_pos], v1_ring[nxt]);
      iv2 = blend(v2_ring[ring_pos], v2_ring[nxt]);
      ic1 = blend(c1_ring[ring_pos], c1_ring[nxt]);
      ic2 = blend(c2_ring[ring_pos], c2_ring[nxt]);
      if (op == OP_START) begin
         pair.source1 = sat48(big_type'(ic1) - big_type'(gain_mul(iv1, start_gain)));
         pair.source2 = sat48(big_type'(ic2) - big_type'(gain_mul(iv2, start_gain)));
      end else begin
         a1 = sat48(big_type'(iv1) + big_type'(gain_mul(ic1, surge_less_loss)));
         a2 = sat48(big_type'(iv2) + big_type'(gain_mul(ic2, surge_less_loss)));
         pair.source1 = sat48(-big_type'(sat48(big_type'(gain_mul(a2, surge_gain))
                                               + big_type'(gain_mul(a1, loss_gain)))));
         pair.source2 = sat48(-big_type'(sat48(big_type'(gain_mul(a1, surge_gain))
                                               + big_type'(gain_mul(a2, loss_gain)))));
      end
      last_src1 = pair.source1;
      last_src2 = pair.source2;
      pending_sources.push_back(pair);
   endtask

   task automatic report_mismatch(input string what, input data_type got,
                                  input data_type want);
      errors++;
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
   endtask

   // result checker
   always @(posedge clock) begin
      source_pair_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_sources.size() == 0) begin
            errors++;
            $display("unexpected result word at %0t", $realtime);
         end else begin
            want = pending_sources.pop_front();
            if (rsp_source1_current !== want.source1)
               report_mismatch("source1_current", rsp_source1_current, want.source1);
            if (rsp_source2_current !== want.source2)
               report_mismatch("source2_current", rsp_source2_current, want.source2);
         end
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(0, 7);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet + 1 >= QUIET_MAX) begin
         $display("timeout: no handshake for %0d cycles", QUIET_MAX);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   function automatic data_type rand_data();
      case ($urandom_range(0, 9))
         0: return DATA_MAX;
         1: return DATA_MIN;
         2: return '0;
         3, 4, 5: return data_type'($signed($urandom_range(0, 32'h3ff_ffff))) - (1 <<< 25);
         default: return DATA_W'({$urandom, $urandom});
      endcase
   endfunction

   function automatic gain_type rand_gain();
      case ($urandom_range(0, 7))
         0: return 32'sh7fff_ffff;
         1: return 32'sh8000_0000;
         2, 3: return $signed($urandom);
         default: return $signed($urandom_range(0, 32'h7_ffff)) - 32'sh4_0000;
      endcase
   endfunction

   task automatic send_word(input op_type op, input data_type v1, input data_type c1,
                            input data_type v2, input data_type c2);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_end1_voltage <= v1;
      req_end1_current <= c1;
      req_end2_voltage <= v2;
      req_end2_current <= c2;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      predict_word(op, v1, c1, v2, c2);
   endtask

   task automatic send_random_word();
      int unsigned pick;
      op_type op;
      pick = $urandom_range(0, 99);
      if (pick < 20) op = OP_LOAD;
      else if (pick < 35) op = OP_START;
      else if (pick < 95) op = OP_UPDATE;
      else op = OP_UNUSED;
      send_word(op, rand_data(), rand_data(), rand_data(), rand_data());
   endtask

   // pause the sender until every expected result is back and the block is quiet
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_sources.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_GAIN_SURGE:       surge_gain = value;
         CSR_GAIN_LOSS:        loss_gain = value;
         CSR_SURGE_MINUS_LOSS: surge_less_loss = value;
         CSR_INIT_GAIN:        start_gain = value;
         CSR_INTERP_WEIGHT:    alpha = value[WEIGHT_W-1:0];
         CSR_DELAY_SLOTS:      slots = value[SLOTS_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input gain_type gs, input gain_type gl, input gain_type sml,
                            input gain_type ig, input logic [WEIGHT_W-1:0] w,
                            input logic [SLOTS_W-1:0] len);
      drain();
      write_reg(CSR_GAIN_SURGE, gs);
      write_reg(CSR_GAIN_LOSS, gl);
      write_reg(CSR_SURGE_MINUS_LOSS, sml);
      write_reg(CSR_INIT_GAIN, ig);
      write_reg(CSR_INTERP_WEIGHT, CSR_DATA_W'(w));
      write_reg(CSR_DELAY_SLOTS, CSR_DATA_W'(len));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // change only the ring length, with nothing in flight
   task automatic set_ring_slots(input logic [SLOTS_W-1:0] len);
      drain();
      write_reg(CSR_DELAY_SLOTS, CSR_DATA_W'(len));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // fill the low slots once; later tests keep every read inside them
   task automatic test_preload();
      set_ring_slots(SLOTS_W'(PRELOAD_SLOTS));
      for (int k = 0; k < PRELOAD_SLOTS; k++)
         send_word(OP_LOAD, rand_data(), rand_data(), rand_data(), rand_data());
   endtask

   task automatic test_directed();
      configure(32'sh0000_8000, 32'sh0000_1000, 32'sh0032_0000, 32'sh0000_0200,
                17'd65536, 11'd1024);
      send_word(OP_START, 48'sd65536, 48'sd131072, -48'sd65536, 48'sd0);
      send_word(OP_UPDATE, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX);
      send_word(OP_UPDATE, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN);
      send_word(OP_UNUSED, DATA_MAX, DATA_MIN, DATA_MAX, DATA_MIN);
      send_word(OP_LOAD, DATA_MIN, DATA_MAX, DATA_MIN, DATA_MAX);
      send_word(OP_UPDATE, '0, '0, '0, '0);
      send_word(OP_START, '0, '0, '0, '0);
      configure(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                17'd0, 11'd1024);
      send_word(OP_UPDATE, DATA_MAX, DATA_MIN, DATA_MIN, DATA_MAX);
      send_word(OP_START, '0, '0, '0, '0);
      send_word(OP_UPDATE, 48'sd1, -48'sd1, 48'sd1, -48'sd1);
      // weight above one acts as one
      configure(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                17'h1ffff, 11'd1024);
      send_word(OP_UPDATE, -48'sd1, 48'sd1, -48'sd1, 48'sd1);
      send_word(OP_START, '0, '0, '0, '0);
      send_word(OP_UPDATE, DATA_MIN, DATA_MAX, DATA_MAX, DATA_MIN);
   endtask

   // clamped and shortened rings, including an index left past the new end
   task automatic test_ring_lengths();
      logic [SLOTS_W-1:0] lens [5] = '{11'd0, 11'd2047, 11'd1, 11'd3, 11'd1024};
      foreach (lens[n]) begin
         configure(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                   17'($urandom_range(0, 65536)), lens[n]);
         repeat (12) send_random_word();
      end
   endtask

   task automatic test_random();
      for (int phase = 0; phase < 10; phase++) begin
         idle_on = (phase < 8) && (phase % 3 != 2);
         // bring the index back to slot zero so a long ring stays in the filled slots
         set_ring_slots(11'd1);
         send_word(OP_LOAD, rand_data(), rand_data(), rand_data(), rand_data());
         configure(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                   ($urandom_range(0, 5) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536)),
                   ($urandom_range(0, 3) == 0) ? 11'($urandom) : 11'($urandom_range(1, 40)));
         repeat (70) send_random_word();
      end
      idle_on = 1'b0;
   endtask

   initial begin
      ring_pos = 0;
      last_src1 = '0;
      last_src2 = '0;
      surge_gain = '0;
      loss_gain = '0;
      surge_less_loss = '0;
      start_gain = '0;
      alpha = ONE_Q16;
      slots = 11'd1024;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_on = 1'b1;
      test_preload();
      test_directed();
      test_ring_lengths();
      test_random();
      drain();
      $display("sent %0d words and checked %0d source current pairs", words_sent,
               results_seen);
      $display("covered load, start, update and unused codes over clamped ring lengths");
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", errors);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
